// File: rtl/chc_pkg.sv
// Package for the coefficient header checker: header constants, status codes,
// the header field struct and the header end helper. No dependencies.
`timescale 1ns / 1ps

package chc_pkg;

    localparam int COUNT_BITS_DEF = 26;

    localparam int WORD_W     = 16;
    localparam int STATUS_W   = 3;
    localparam int MASK_W     = 3;
    localparam int NUM_FIELDS = 7;

    localparam logic [WORD_W-1:0] MAGIC_WORD   = 16'h7072;
    localparam logic [WORD_W-1:0] CHECK_SEED   = 16'hA569;
    localparam logic [WORD_W-1:0] ABSENT_A_DIM = 16'd77;

    localparam int HDR_BASE    = 5;
    localparam int A_HDR_LANES = 5;
    localparam int B_HDR_LANES = 3;
    localparam int C_HDR_LANES = 1;

    localparam int B_GROUP_MUL = 380;
    localparam int A_EXTRA_MUL = 171;
    localparam int A_DIM_MUL   = 28;
    localparam int C_DIM_MUL   = 314;
    localparam int TABLE_BIAS  = 79;
    localparam int C_BIAS      = 1;
    localparam int COUNT_BIAS  = 11;

    localparam int TERM_W = 25;
    localparam int SUM_W  = 26;

    localparam int OUT_DEPTH = 8;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_MAGIC = 3'd2,
        ST_B_NO_A    = 3'd3,
        ST_TRUNC     = 3'd4
    } status_t;

    typedef struct packed {
        logic [WORD_W-1:0] c_dimension;
        logic [WORD_W-1:0] b_groups;
        logic [WORD_W-1:0] b_extra;
        logic [WORD_W-1:0] b_dimension;
        logic [WORD_W-1:0] a_extra;
        logic [WORD_W-1:0] a_option;
        logic [WORD_W-1:0] a_dimension;
    } hdr_fields_t;

    function automatic logic [3:0] hdr_end(input logic [MASK_W-1:0] pres);
        return 4'(HDR_BASE)
            + (pres[0] ? 4'(A_HDR_LANES) : 4'd0)
            + (pres[1] ? 4'(B_HDR_LANES) : 4'd0)
            + (pres[2] ? 4'(C_HDR_LANES) : 4'd0);
    endfunction

endpackage

// File: rtl/coefficient_header_checker_unit.sv
// Top level of the coefficient header checker: lane state, result line, output queue.
// Depends on chc_pkg, chc_count and chc_fifo.
`timescale 1ns / 1ps

// Accepts one lane per clock cycle while s_axis_tready is high, with no gaps between
// arrays. The result of an array passes through the fin_*_reg finish registers before
// it enters the output queue; that delay is set by the two-stage lane count adder
// (chc_count) whose total must settle before the truncation check. The queue holds
// eight results; s_axis_tready drops only while queued plus in-flight results
// would fill it.

module coefficient_header_checker_unit
    import chc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    localparam int OUT_BITS = STATUS_W + 1 + WORD_W + COUNT_BITS + MASK_W
                            + NUM_FIELDS * WORD_W,
    localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [WORD_W-1:0] s_axis_tdata,  // lane_word
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // status, sum_match, sum_value, lane_span, present_mask,
    // a_dimension, a_option, a_extra, b_dimension, b_extra, b_groups, c_dimension
    output logic [OUT_W-1:0]  m_axis_tdata
);

    localparam int LVL_W = $clog2(OUT_DEPTH) + 1;

    localparam logic [COUNT_BITS-1:0] LANE_MAGIC  = COUNT_BITS'(0);
    localparam logic [COUNT_BITS-1:0] LANE_SUM    = COUNT_BITS'(1);
    localparam logic [COUNT_BITS-1:0] LANE_PRES_A = COUNT_BITS'(2);
    localparam logic [COUNT_BITS-1:0] LANE_PRES_B = COUNT_BITS'(3);
    localparam logic [COUNT_BITS-1:0] LANE_PRES_C = COUNT_BITS'(4);
    localparam logic [COUNT_BITS-1:0] LANE_HDR    = COUNT_BITS'(HDR_BASE);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0] lane_idx_reg, lane_idx_next;
    logic [WORD_W-1:0]     csum_reg, csum_next;
    logic [WORD_W-1:0]     stored_reg, stored_next;
    logic [MASK_W-1:0]     presence_reg, presence_next;
    hdr_fields_t           fields_reg, fields_next;
    status_t               err_reg, err_next;

    logic [2:0]            fin_vld_reg, fin_vld_next;
    logic [COUNT_BITS-1:0] fin_cnt_reg [3];
    status_t               fin_err_reg [3];
    logic [WORD_W-1:0]     fin_csum_reg [3];
    logic [WORD_W-1:0]     fin_stored_reg [3];

    logic                  accept;
    logic [COUNT_BITS-1:0] lane_upd;
    logic [WORD_W-1:0]     csum_upd;
    logic [WORD_W-1:0]     stored_upd;
    status_t               err_upd;
    logic [3:0]            hend;
    logic                  in_hdr;
    logic [3:0]            offset;
    logic [3:0]            b_base;
    logic [3:0]            c_base;
    logic [COUNT_BITS-1:0] exp_count;

    status_t               res_status;
    logic                  res_show;
    logic                  res_csum_ok;
    logic [WORD_W-1:0]     res_csum;
    logic [COUNT_BITS-1:0] res_active;
    logic [MASK_W-1:0]     res_mask;
    hdr_fields_t           res_fields;
    logic [OUT_W-1:0]      res_data;

    logic                  fifo_push;
    logic                  fifo_pop;
    logic [LVL_W-1:0]      fifo_level;
    logic [LVL_W:0]        occupancy;

    chc_count #(
        .COUNT_BITS (COUNT_BITS)
    ) u_count (
        .clk      (clk),
        .rst_n    (rst_n),
        .presence (presence_reg),
        .fields   (fields_reg),
        .count    (exp_count)
    );

    assign occupancy     = (LVL_W + 1)'(fifo_level) + (LVL_W + 1)'($countones(fin_vld_reg));
    assign s_axis_tready = (occupancy < (LVL_W + 1)'(OUT_DEPTH));
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign hend   = hdr_end(presence_reg);
    assign in_hdr = (lane_idx_reg < COUNT_BITS'(hend));
    assign offset = lane_idx_reg[3:0] - 4'(HDR_BASE);
    assign b_base = presence_reg[0] ? 4'(A_HDR_LANES) : 4'd0;
    assign c_base = b_base + (presence_reg[1] ? 4'(B_HDR_LANES) : 4'd0);

    always_comb
    begin
        lane_upd   = (lane_idx_reg == COUNT_MAX) ? lane_idx_reg : lane_idx_reg + 1'b1;
        csum_upd   = csum_reg;
        stored_upd = stored_reg;
        err_upd    = err_reg;
        if (lane_idx_reg >= LANE_PRES_A && (in_hdr || lane_idx_reg < exp_count))
        begin
            csum_upd = csum_reg ^ s_axis_tdata;
        end
        if (lane_idx_reg == LANE_MAGIC)
        begin
            if (s_axis_tdata != MAGIC_WORD)
            begin
                err_upd = ST_BAD_MAGIC;
            end
        end
        else if (lane_idx_reg == LANE_SUM)
        begin
            stored_upd = s_axis_tdata;
        end
        else if (lane_idx_reg == LANE_PRES_C)
        begin
            if (err_reg == ST_OK && presence_reg[1] && !presence_reg[0])
            begin
                err_upd = ST_B_NO_A;
            end
        end
    end

    // Presence and fields are cleared at the third lane of the next array, so they
    // stay frozen while the lane count and the result of the previous one settle.
    always_comb
    begin
        lane_idx_next = lane_idx_reg;
        csum_next     = csum_reg;
        stored_next   = stored_reg;
        presence_next = presence_reg;
        fields_next   = fields_reg;
        err_next      = err_reg;
        fin_vld_next  = {fin_vld_reg[1:0], accept && s_axis_tlast};
        if (accept)
        begin
            lane_idx_next = lane_upd;
            csum_next     = csum_upd;
            stored_next   = stored_upd;
            err_next      = err_upd;
            if (lane_idx_reg == LANE_PRES_A)
            begin
                presence_next = {2'b00, s_axis_tdata != '0};
                fields_next   = '0;
            end
            else if (lane_idx_reg == LANE_PRES_B)
            begin
                presence_next[1] = (s_axis_tdata != '0);
            end
            else if (lane_idx_reg == LANE_PRES_C)
            begin
                presence_next[2] = (s_axis_tdata != '0);
            end
            else if (lane_idx_reg >= LANE_HDR && in_hdr)
            begin
                if (presence_reg[0] && offset == 4'd0)
                begin
                    fields_next.a_dimension = s_axis_tdata;
                end
                if (presence_reg[0] && offset == 4'd1)
                begin
                    fields_next.a_option = s_axis_tdata;
                end
                if (presence_reg[0] && offset == 4'd2)
                begin
                    fields_next.a_extra = s_axis_tdata;
                end
                if (presence_reg[1] && offset == b_base)
                begin
                    fields_next.b_dimension = s_axis_tdata;
                end
                if (presence_reg[1] && offset == b_base + 4'd1)
                begin
                    fields_next.b_extra = s_axis_tdata;
                end
                if (presence_reg[1] && offset == b_base + 4'd2)
                begin
                    fields_next.b_groups = s_axis_tdata;
                end
                if (presence_reg[2] && offset == c_base)
                begin
                    fields_next.c_dimension = s_axis_tdata;
                end
            end
            if (s_axis_tlast)
            begin
                lane_idx_next = '0;
                csum_next     = CHECK_SEED;
                stored_next   = '0;
                err_next      = ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_idx_reg <= '0;
            csum_reg     <= CHECK_SEED;
            stored_reg   <= '0;
            presence_reg <= '0;
            fields_reg   <= '0;
            err_reg      <= ST_OK;
            fin_vld_reg  <= '0;
        end
        else
        begin
            lane_idx_reg <= lane_idx_next;
            csum_reg     <= csum_next;
            stored_reg   <= stored_next;
            presence_reg <= presence_next;
            fields_reg   <= fields_next;
            err_reg      <= err_next;
            fin_vld_reg  <= fin_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_cnt_reg[0]    <= lane_upd;
        fin_err_reg[0]    <= err_upd;
        fin_csum_reg[0]   <= csum_upd;
        fin_stored_reg[0] <= stored_upd;
        for (int i = 1; i < 3; i++)
        begin
            fin_cnt_reg[i]    <= fin_cnt_reg[i-1];
            fin_err_reg[i]    <= fin_err_reg[i-1];
            fin_csum_reg[i]   <= fin_csum_reg[i-1];
            fin_stored_reg[i] <= fin_stored_reg[i-1];
        end
    end

    always_comb
    begin
        if (fin_cnt_reg[2] < LANE_HDR)
        begin
            res_status = ST_SHORT;
        end
        else if (fin_err_reg[2] != ST_OK)
        begin
            res_status = fin_err_reg[2];
        end
        else if (fin_cnt_reg[2] < COUNT_BITS'(hend) || fin_cnt_reg[2] < exp_count)
        begin
            res_status = ST_TRUNC;
        end
        else
        begin
            res_status = ST_OK;
        end

        res_show    = (res_status == ST_OK) || (res_status == ST_B_NO_A)
                   || (res_status == ST_TRUNC);
        res_csum_ok = (res_status == ST_OK) && (fin_csum_reg[2] == fin_stored_reg[2]);
        res_csum    = (res_status == ST_OK) ? fin_csum_reg[2] : '0;
        res_active  = '0;
        if (res_status == ST_OK
            || (res_status == ST_TRUNC && fin_cnt_reg[2] >= COUNT_BITS'(hend)))
        begin
            res_active = exp_count;
        end
        res_mask   = res_show ? presence_reg : '0;
        res_fields = res_show ? fields_reg : '0;
        if (res_show && !presence_reg[0])
        begin
            res_fields.a_dimension = ABSENT_A_DIM;
        end

        res_data = OUT_W'({res_fields.c_dimension, res_fields.b_groups,
                           res_fields.b_extra, res_fields.b_dimension,
                           res_fields.a_extra, res_fields.a_option,
                           res_fields.a_dimension, res_mask, res_active,
                           res_csum, res_csum_ok, res_status});
    end

    assign fifo_push = fin_vld_reg[2];
    assign fifo_pop  = m_axis_tvalid && m_axis_tready;

    chc_fifo #(
        .DATA_W (OUT_W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .push_data (res_data),
        .pop       (fifo_pop),
        .pop_data  (m_axis_tdata),
        .not_empty (m_axis_tvalid),
        .level     (fifo_level)
    );

endmodule

// File: rtl/chc_count.sv
// Active lane count pipeline: per-table terms, then total with saturation.
// Depends on chc_pkg.
`timescale 1ns / 1ps

module chc_count
    import chc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [MASK_W-1:0]     presence,
    input  hdr_fields_t           fields,
    output logic [COUNT_BITS-1:0] count
);

    localparam int CMP_W = (COUNT_BITS > SUM_W) ? COUNT_BITS : SUM_W;

    logic [TERM_W-1:0]     term_a_reg, term_a_next;
    logic [TERM_W-1:0]     term_b_reg, term_b_next;
    logic [TERM_W-1:0]     term_c_reg, term_c_next;
    logic [4:0]            base_reg, base_next;
    logic [SUM_W-1:0]      sum;
    logic [CMP_W-1:0]      sum_ext;
    logic [CMP_W-1:0]      max_ext;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    always_comb
    begin
        term_a_next = '0;
        term_b_next = '0;
        term_c_next = '0;
        if (presence[0])
        begin
            term_a_next = TERM_W'(fields.a_extra) * TERM_W'(A_EXTRA_MUL)
                        + (TERM_W'(fields.a_option) << 1)
                        + TERM_W'(fields.a_dimension) * TERM_W'(A_DIM_MUL)
                        + TERM_W'(TABLE_BIAS);
        end
        if (presence[1])
        begin
            term_b_next = TERM_W'(fields.b_groups) * TERM_W'(B_GROUP_MUL)
                        + TERM_W'(fields.b_dimension)
                        + TERM_W'(fields.b_extra)
                        + TERM_W'(TABLE_BIAS);
        end
        if (presence[2])
        begin
            term_c_next = TERM_W'(fields.c_dimension) * TERM_W'(C_DIM_MUL)
                        + TERM_W'(C_BIAS);
        end
        base_next = 5'(hdr_end(presence)) + 5'(COUNT_BIAS);
    end

    always_comb
    begin
        sum = SUM_W'(base_reg) + SUM_W'(term_a_reg) + SUM_W'(term_b_reg)
            + SUM_W'(term_c_reg);
        sum_ext = CMP_W'(sum);
        max_ext = CMP_W'({COUNT_BITS{1'b1}});
        count_next = (sum_ext > max_ext) ? COUNT_BITS'(max_ext) : COUNT_BITS'(sum_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_a_reg <= '0;
            term_b_reg <= '0;
            term_c_reg <= '0;
            base_reg   <= '0;
            count_reg  <= '0;
        end
        else
        begin
            term_a_reg <= term_a_next;
            term_b_reg <= term_b_next;
            term_c_reg <= term_c_next;
            base_reg   <= base_next;
            count_reg  <= count_next;
        end
    end

    assign count = count_reg;

endmodule

// File: rtl/chc_fifo.sv
// Result queue: register array with write and read pointers and a fill level.
// Depends on chc_pkg for the depth.
`timescale 1ns / 1ps

module chc_fifo
    import chc_pkg::*;
#(
    parameter int DATA_W = 168
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic [DATA_W-1:0]              push_data,
    input  logic                           pop,
    output logic [DATA_W-1:0]              pop_data,
    output logic                           not_empty,
    output logic [$clog2(OUT_DEPTH):0]     level
);

    localparam int PTR_W = $clog2(OUT_DEPTH);

    logic [DATA_W-1:0] mem_reg [OUT_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]    level_reg, level_next;

    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        level_next  = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data  = mem_reg[rd_ptr_reg];
    assign not_empty = (level_reg != '0);
    assign level     = level_reg;

endmodule

// File: verif/tb.sv
// Testbench for coefficient_header_checker_unit: streams coefficient arrays with random
// gaps and stalls, predicts each header verdict and checks it. Depends on chc_pkg.
`timescale 1ns / 1ps

module tb;
    import chc_pkg::*;

    localparam int COUNT_BITS = COUNT_BITS_DEF;

    typedef struct packed {
        logic [WORD_W-1:0]     c_dimension;
        logic [WORD_W-1:0]     b_groups;
        logic [WORD_W-1:0]     b_extra;
        logic [WORD_W-1:0]     b_dimension;
        logic [WORD_W-1:0]     a_extra;
        logic [WORD_W-1:0]     a_option;
        logic [WORD_W-1:0]     a_dimension;
        logic [MASK_W-1:0]     present_mask;
        logic [COUNT_BITS-1:0] lane_span;
        logic [WORD_W-1:0]     sum_value;
        logic                  sum_match;
        status_t               status;
    } verdict_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0]        lane_pos;
        logic [WORD_W-1:0]            xor_sum;
        logic [WORD_W-1:0]            stored_sum;
        logic [MASK_W-1:0]            present;
        logic [NUM_FIELDS-1:0][WORD_W-1:0] fields;
        logic [3:0]                   hdr_last;
        logic [COUNT_BITS-1:0]        target;
        status_t                      fault;
    } scan_state_t;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
        logic              hold;
    } lane_item_t;

    localparam int RESULT_W = (($bits(verdict_t) + 7) / 8) * 8;
    localparam longint unsigned LANE_MAX = (64'd1 << COUNT_BITS) - 1;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [WORD_W-1:0]   s_axis_tdata = '0;
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [RESULT_W-1:0] m_axis_tdata;

    lane_item_t  lane_queue[$];
    verdict_t    verdict_queue[$];
    scan_state_t live_state;
    int          array_count = 0;
    int          lane_count = 0;
    int          failures = 0;
    int          send_gap = 0;
    int          send_quiet = 0;
    int          stall_left = 0;
    int          recv_quiet = 0;

    coefficient_header_checker_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    function automatic scan_state_t idle_state();
        scan_state_t s;
        s = '0;
        s.xor_sum  = CHECK_SEED;
        s.hdr_last = 4'(HDR_BASE);
        s.fault    = ST_OK;
        return s;
    endfunction

    function automatic logic [COUNT_BITS-1:0] lane_total(input scan_state_t s);
        longint unsigned n;
        n = s.hdr_last;
        if (s.present[1])
            n += longint'(s.fields[3]) + B_GROUP_MUL * longint'(s.fields[5])
               + longint'(s.fields[4]) + TABLE_BIAS;
        if (s.present[0])
            n += A_EXTRA_MUL * longint'(s.fields[2]) + TABLE_BIAS
               + 2 * longint'(s.fields[1]) + A_DIM_MUL * longint'(s.fields[0]);
        n += COUNT_BIAS;
        if (s.present[2])
            n += C_DIM_MUL * longint'(s.fields[6]) + C_BIAS;
        return (n > LANE_MAX) ? COUNT_BITS'(LANE_MAX) : COUNT_BITS'(n);
    endfunction

    function automatic bit lane_step(inout scan_state_t s, input logic [WORD_W-1:0] w,
                                     input bit last, output verdict_t v);
        longint unsigned p;
        longint unsigned cnt;
        longint unsigned o;
        bit              taken;
        status_t         st;
        p = s.lane_pos;
        v = '0;
        if (p >= 2 && (p < s.hdr_last || p < s.target))
            s.xor_sum ^= w;
        if (p == 0)
        begin
            if (w != MAGIC_WORD)
                s.fault = ST_BAD_MAGIC;
        end
        else if (p == 1)
            s.stored_sum = w;
        else if (p <= 4)
        begin
            if (w != '0)
                s.present[p-2] = 1'b1;
            if (p == 4)
            begin
                s.hdr_last = 4'(HDR_BASE + (s.present[0] ? A_HDR_LANES : 0)
                           + (s.present[1] ? B_HDR_LANES : 0)
                           + (s.present[2] ? C_HDR_LANES : 0));
                if (s.fault == ST_OK && s.present[1] && !s.present[0])
                    s.fault = ST_B_NO_A;
            end
        end
        else if (p < s.hdr_last)
        begin
            o = p - HDR_BASE;
            taken = 1'b0;
            if (s.present[0])
            begin
                if (o < 3)
                begin
                    s.fields[o] = w;
                    taken = 1'b1;
                end
                else if (o < A_HDR_LANES)
                    taken = 1'b1;
                else
                    o -= A_HDR_LANES;
            end
            if (!taken && s.present[1])
            begin
                if (o < B_HDR_LANES)
                begin
                    s.fields[3+o] = w;
                    taken = 1'b1;
                end
                else
                    o -= B_HDR_LANES;
            end
            if (!taken && s.present[2] && o == 0)
                s.fields[6] = w;
        end
        if (p >= 4)
            s.target = lane_total(s);
        s.lane_pos = (p < LANE_MAX) ? COUNT_BITS'(p + 1) : COUNT_BITS'(LANE_MAX);
        if (!last)
            return 1'b0;

        cnt = s.lane_pos;
        if (cnt < 5)
            st = ST_SHORT;
        else if (s.fault != ST_OK)
            st = s.fault;
        else if (cnt < s.hdr_last || cnt < s.target)
            st = ST_TRUNC;
        else
            st = ST_OK;
        v.status = st;
        if (st == ST_OK)
        begin
            v.sum_match = (s.xor_sum == s.stored_sum);
            v.sum_value = s.xor_sum;
            v.lane_span = s.target;
        end
        else if (st == ST_TRUNC && cnt >= s.hdr_last)
            v.lane_span = s.target;
        if (st == ST_OK || st == ST_B_NO_A || st == ST_TRUNC)
        begin
            v.present_mask = s.present;
            v.a_dimension  = s.present[0] ? s.fields[0] : ABSENT_A_DIM;
            v.a_option     = s.fields[1];
            v.a_extra      = s.fields[2];
            v.b_dimension  = s.fields[3];
            v.b_extra      = s.fields[4];
            v.b_groups     = s.fields[5];
            v.c_dimension  = s.fields[6];
        end
        s = idle_state();
        return 1'b1;
    endfunction

    function automatic longint unsigned header_lanes(input logic [WORD_W-1:0] words[$]);
        scan_state_t s;
        verdict_t    v;
        s = idle_state();
        foreach (words[i])
            void'(lane_step(s, words[i], 1'b0, v));
        return s.target;
    endfunction

    function automatic void emit_array(input logic [WORD_W-1:0] words[$], input bit hold,
                                       input bit fix_sum);
        scan_state_t s;
        verdict_t    v;
        lane_item_t  it;
        if (fix_sum)
        begin
            s = idle_state();
            foreach (words[i])
                if (lane_step(s, words[i], i == words.size() - 1, v) && v.status == ST_OK)
                    words[1] = v.sum_value;
        end
        foreach (words[i])
        begin
            it.word = words[i];
            it.last = (i == words.size() - 1);
            it.hold = hold && (i == 0);
            lane_queue = {lane_queue, it};
        end
        array_count++;
        lane_count += words.size();
    endfunction

    function automatic logic [WORD_W-1:0] presence_flag(input bit on);
        return on ? WORD_W'($urandom_range(1, 65535)) : '0;
    endfunction

    function automatic void random_array();
        logic [WORD_W-1:0] words[$];
        int                kind;
        int                pick;
        int                len;
        int                hdr;
        bit                pa;
        bit                pb;
        bit                pc;
        longint unsigned   act;
        kind = $urandom_range(0, 99);
        if (kind < 55)
        begin
            pick = $urandom_range(0, 99);
            pa = (pick >= 70);
            pb = (pick >= 90);
            pc = (pick >= 45 && pick < 70) || (pick >= 85 && pick < 90) || (pick >= 95);
            words = {words, MAGIC_WORD};
            words = {words, WORD_W'(0)};
            words = {words, presence_flag(pa)};
            words = {words, presence_flag(pb)};
            words = {words, presence_flag(pc)};
            if (pa)
            begin
                words = {words, WORD_W'($urandom_range(0, 1))};
                words = {words, WORD_W'($urandom_range(0, 3))};
                words = {words, WORD_W'(0)};
                words = {words, WORD_W'($urandom)};
                words = {words, WORD_W'($urandom)};
            end
            if (pb)
            begin
                words = {words, WORD_W'($urandom_range(0, 3))};
                words = {words, WORD_W'($urandom_range(0, 3))};
                words = {words, WORD_W'(0)};
            end
            if (pc)
                words = {words, WORD_W'(0)};
            act = header_lanes(words);
            len = int'(act) + $urandom_range(0, 3);
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(words.size(), int'(act) - 1);
        end
        else if (kind < 63)
        begin
            len = $urandom_range(1, 4);
            words = {words, ($urandom_range(0, 1) ? MAGIC_WORD : WORD_W'($urandom))};
        end
        else if (kind < 73)
        begin
            len = $urandom_range(5, 20);
            words = {words, ($urandom_range(0, 1) ? MAGIC_WORD ^ (16'd1 << $urandom_range(0, 15))
                                                  : WORD_W'($urandom))};
        end
        else if (kind < 81)
        begin
            len = $urandom_range(5, 16);
            words = {words, MAGIC_WORD};
            words = {words, WORD_W'($urandom)};
            words = {words, WORD_W'(0)};
            words = {words, presence_flag(1'b1)};
            words = {words, presence_flag($urandom_range(0, 1))};
        end
        else
        begin
            pa = $urandom_range(0, 1);
            pb = $urandom_range(0, 1);
            pc = $urandom_range(0, 1);
            words = {words, MAGIC_WORD};
            words = {words, WORD_W'($urandom)};
            words = {words, presence_flag(pa)};
            words = {words, presence_flag(pb)};
            words = {words, presence_flag(pc)};
            hdr = HDR_BASE + (pa ? A_HDR_LANES : 0) + (pb ? B_HDR_LANES : 0)
                + (pc ? C_HDR_LANES : 0);
            while (words.size() < hdr)
                words = {words, (($urandom_range(0, 3) == 0) ? 16'hFFFF : WORD_W'($urandom))};
            len = $urandom_range(5, hdr + 20);
        end
        while (words.size() < len)
            words = {words, WORD_W'($urandom)};
        while (words.size() > len)
            void'(words.pop_back());
        emit_array(words, (array_count % 9 == 4) || ($urandom_range(0, 19) == 0),
                   $urandom_range(0, 3) != 0);
    endfunction

    function automatic int draw_gap(inout int quiet);
        int r;
        if (quiet > 0)
        begin
            quiet--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
            quiet = $urandom_range(50, 200);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void compare_field(input string name, input longint unsigned want,
                                          input longint unsigned got);
        if (want != got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    function automatic void check_verdict(input verdict_t got);
        verdict_t want;
        if (verdict_queue.size() == 0)
        begin
            $error("result transaction with no expected result pending");
            failures++;
            return;
        end
        want = verdict_queue.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("sum_match", want.sum_match, got.sum_match);
        compare_field("sum_value", want.sum_value, got.sum_value);
        compare_field("lane_span", want.lane_span, got.lane_span);
        compare_field("present_mask", want.present_mask, got.present_mask);
        compare_field("a_dimension", want.a_dimension, got.a_dimension);
        compare_field("a_option", want.a_option, got.a_option);
        compare_field("a_extra", want.a_extra, got.a_extra);
        compare_field("b_dimension", want.b_dimension, got.b_dimension);
        compare_field("b_extra", want.b_extra, got.b_extra);
        compare_field("b_groups", want.b_groups, got.b_groups);
        compare_field("c_dimension", want.c_dimension, got.c_dimension);
    endfunction

    // predict on each accepted lane, then present the next one
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t   v;
        lane_item_t it;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tlast  <= 1'b0;
            live_state = idle_state();
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                if (lane_step(live_state, s_axis_tdata, s_axis_tlast, v))
                    verdict_queue = {verdict_queue, v};
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                    s_axis_tdata  <= WORD_W'($urandom);
                end
                else if (lane_queue.size() != 0
                         && !(lane_queue[0].hold && verdict_queue.size() != 0))
                begin
                    it = lane_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= it.word;
                    s_axis_tlast  <= it.last;
                    send_gap = draw_gap(send_quiet);
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_verdict(verdict_t'(m_axis_tdata[$bits(verdict_t)-1:0]));
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left = draw_gap(recv_quiet);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        logic [WORD_W-1:0] words[$];
        int                wait_cycles;
        live_state = idle_state();

        words = {16'hFFFF};
        emit_array(words, 1'b0, 1'b0);
        words = {MAGIC_WORD, 16'h0000, 16'h0000, 16'h0000};
        emit_array(words, 1'b0, 1'b0);
        words = {16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000};
        emit_array(words, 1'b0, 1'b0);
        words = {MAGIC_WORD, 16'h0000, 16'h0000, 16'h8000, 16'h0001,
                 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        emit_array(words, 1'b0, 1'b0);
        words = {MAGIC_WORD, 16'h0000, 16'h0001, 16'h0001, 16'h0001};
        repeat (9)
            words = {words, 16'hFFFF};
        emit_array(words, 1'b0, 1'b0);
        words = {MAGIC_WORD, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
        repeat (13)
            words = {words, WORD_W'($urandom)};
        emit_array(words, 1'b1, 1'b1);

        while (lane_count < 1300 || array_count < 24)
            random_array();

        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        while (lane_queue.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        wait_cycles = 0;
        while (verdict_queue.size() != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20)
            @(posedge clk);
        if (verdict_queue.size() != 0)
        begin
            $error("%0d expected results never arrived", verdict_queue.size());
            failures++;
        end
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
